### hdl/lpl_pkg.sv
// Package for the lookahead peak limiter: register codes, scaling constants, log and power tables.
package lpl_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_CEILING   = 2'd1,
        REG_RELEASE   = 2'd2,
        REG_LOOKAHEAD = 2'd3
    } t_reg_idx;

    // dB per log2 unit and log2 units per dB, both Q16
    localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
    localparam logic [13:0] LOG2_PER_DB = 14'd10885;
    // Lowest ceiling, Q8 dB magnitude
    localparam logic [12:0] CEIL_MAX_ATTEN = 13'd3072;

    // Fraction of log2 over one octave, Q16, 33 points
    function automatic logic [16:0] log2_tab(input logic [5:0] idx);
        logic [16:0] v;
        case (idx)
            6'd0:  v = 17'd0;     6'd1:  v = 17'd2909;  6'd2:  v = 17'd5732;
            6'd3:  v = 17'd8473;  6'd4:  v = 17'd11136; 6'd5:  v = 17'd13727;
            6'd6:  v = 17'd16248; 6'd7:  v = 17'd18704; 6'd8:  v = 17'd21098;
            6'd9:  v = 17'd23432; 6'd10: v = 17'd25711; 6'd11: v = 17'd27935;
            6'd12: v = 17'd30109; 6'd13: v = 17'd32234; 6'd14: v = 17'd34312;
            6'd15: v = 17'd36345; 6'd16: v = 17'd38336; 6'd17: v = 17'd40285;
            6'd18: v = 17'd42195; 6'd19: v = 17'd44068; 6'd20: v = 17'd45904;
            6'd21: v = 17'd47705; 6'd22: v = 17'd49472; 6'd23: v = 17'd51207;
            6'd24: v = 17'd52910; 6'd25: v = 17'd54584; 6'd26: v = 17'd56228;
            6'd27: v = 17'd57845; 6'd28: v = 17'd59434; 6'd29: v = 17'd60996;
            6'd30: v = 17'd62534; 6'd31: v = 17'd64047; 6'd32: v = 17'd65536;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // 2^-x over one octave, Q16, 33 points
    function automatic logic [16:0] pow2n_tab(input logic [5:0] idx);
        logic [16:0] v;
        case (idx)
            6'd0:  v = 17'd65536; 6'd1:  v = 17'd64132; 6'd2:  v = 17'd62757;
            6'd3:  v = 17'd61413; 6'd4:  v = 17'd60097; 6'd5:  v = 17'd58809;
            6'd6:  v = 17'd57549; 6'd7:  v = 17'd56316; 6'd8:  v = 17'd55109;
            6'd9:  v = 17'd53928; 6'd10: v = 17'd52773; 6'd11: v = 17'd51642;
            6'd12: v = 17'd50535; 6'd13: v = 17'd49452; 6'd14: v = 17'd48393;
            6'd15: v = 17'd47356; 6'd16: v = 17'd46341; 6'd17: v = 17'd45348;
            6'd18: v = 17'd44376; 6'd19: v = 17'd43426; 6'd20: v = 17'd42495;
            6'd21: v = 17'd41584; 6'd22: v = 17'd40693; 6'd23: v = 17'd39822;
            6'd24: v = 17'd38968; 6'd25: v = 17'd38133; 6'd26: v = 17'd37316;
            6'd27: v = 17'd36516; 6'd28: v = 17'd35734; 6'd29: v = 17'd34968;
            6'd30: v = 17'd34219; 6'd31: v = 17'd33486; 6'd32: v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### hdl/lookahead_peak_limiter.sv
// Lookahead peak limiter top level: delay line memory, gain computation sequencer, APB registers.
//
// While limiting, each sample word passes from acceptance to the output register via one
// sequencer step each for magnitude, normalization, log interpolation, dB scaling, release,
// log2 scaling, power interpolation and output scaling; disabled words skip these steps;
// the next word is taken in the cycle after the result enters the output register. The
// delay line sits in a synchronous single-write, single-read memory of DELAY_DEPTH words;
// entries not yet written since reset or a lookahead write read as zero through a wrap
// flag, so no clearing pass is needed. Writing lookahead_len restarts the delay line and
// the held gain reduction.
module lookahead_peak_limiter #(
    parameter int DELAY_DEPTH  = 512,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample input
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    // sample output
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic        [11:0]             o_gain_reduction,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [3:0]              paddr,
    input  logic        [31:0]             pwdata,
    output logic        [31:0]             prdata,
    output logic                           pready
);

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int SW = SAMPLE_WIDTH;
    localparam logic [AW-1:0] LAST_MAX = AW'(DELAY_DEPTH - 1);
    localparam logic [5:0] SW_M1 = 6'(SAMPLE_WIDTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAG, ST_NORM, ST_LOG, ST_ATTEN, ST_REL, ST_EXP, ST_POW, ST_SCALE, ST_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic        r_enable;
    logic [12:0] r_ceiling;
    logic [15:0] r_release;
    logic [8:0]  r_look;

    // ring control and held gain reduction (Q16 dB magnitude)
    logic [AW-1:0] r_wp;
    logic          r_wrap;
    logic [19:0]   r_gain;

    // per-word working registers
    logic signed [SW-1:0] r_s;
    logic                 r_rd_ok;
    logic [SW-1:0]        r_mag;
    logic [SW-1:0]        r_dmag;
    logic                 r_dneg;
    logic                 r_zero;
    logic [5:0]           r_int;
    logic [4:0]           r_idx;
    logic [9:0]           r_rem;
    logic [20:0]          r_l2;
    logic [23:0]          r_at;
    logic [17:0]          r_l2g;
    logic [16:0]          r_g;
    logic signed [SW-1:0] r_res;
    logic [11:0]          r_red;
    logic signed [SW-1:0] r_mem_q;

    logic signed [SW-1:0] mem [DELAY_DEPTH];

    // ring length handling
    logic [AW-1:0] w_last, w_ptr, w_nxt;
    int unsigned   w_look;
    always_comb begin
        w_look = (r_look == 9'd0) ? 32'd1 : 32'(r_look);
        if (w_look > 32'(DELAY_DEPTH - 1)) begin
            w_last = LAST_MAX;
        end else begin
            w_last = AW'(w_look);
        end
        w_ptr = (r_wp > w_last) ? '0 : r_wp;
        w_nxt = (w_ptr == w_last) ? '0 : w_ptr + AW'(1);
    end

    logic w_in_acc, w_out_free, w_cfg_wr;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !o_valid || !i_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign o_stall    = (r_state != ST_IDLE);
    assign pready     = 1'b1;

    // delay line: write the new word, read the one leaving the ring
    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_enable) begin
            mem[w_ptr] <= i_sample_in;
            r_mem_q    <= mem[w_nxt];
        end
    end

    // leading one and normalization of the magnitude
    logic [5:0]  w_e;
    logic [31:0] w_n;
    always_comb begin
        w_e = 6'd0;
        for (int i = 0; i < SW; i++) begin
            if (r_mag[i]) begin
                w_e = 6'(i);
            end
        end
        w_n = 32'(r_mag) << (6'd31 - w_e);
    end

    // log2 interpolation
    logic [16:0] w_lt0, w_lt1, w_lf;
    logic [26:0] w_lprod;
    logic [21:0] w_l2raw;
    always_comb begin
        w_lt0   = lpl_pkg::log2_tab({1'b0, r_idx});
        w_lt1   = lpl_pkg::log2_tab({1'b0, r_idx} + 6'd1);
        w_lprod = (w_lt1 - w_lt0) * r_rem;
        w_lf    = w_lt0 + 17'(w_lprod >> 10);
        w_l2raw = {r_int, 16'd0} - 22'(w_lf);
    end

    // dB scaling
    logic [39:0] w_atprod;
    assign w_atprod = r_l2 * lpl_pkg::DB_PER_LOG2 + 40'd32768;

    // ceiling as a positive Q16 attenuation
    logic [19:0] w_cd;
    always_comb begin
        if (!r_ceiling[12]) begin
            w_cd = '0;
        end else if ((~r_ceiling + 13'd1) > lpl_pkg::CEIL_MAX_ATTEN) begin
            w_cd = {lpl_pkg::CEIL_MAX_ATTEN[11:0], 8'd0};
        end else begin
            w_cd = {12'(~r_ceiling + 13'd1), 8'd0};
        end
    end

    // wanted reduction and release
    logic [19:0] w_want, w_rnew;
    logic [35:0] w_relprod;
    always_comb begin
        w_want = '0;
        if (!r_zero && (r_at < 24'(w_cd))) begin
            w_want = w_cd - 20'(r_at);
        end
        w_relprod = r_release * (r_gain - w_want);
        if (w_want > r_gain) begin
            w_rnew = w_want;
        end else begin
            w_rnew = w_want + 20'(w_relprod >> 16);
        end
    end

    // log2 of the gain
    logic [33:0] w_l2gprod;
    assign w_l2gprod = r_gain * lpl_pkg::LOG2_PER_DB + 34'd32768;

    // power interpolation
    logic [4:0]  w_pidx;
    logic [10:0] w_prem;
    logic [16:0] w_pt0, w_pt1, w_pg;
    logic [27:0] w_pprod;
    always_comb begin
        w_pidx  = r_l2g[15:11];
        w_prem  = r_l2g[10:0];
        w_pt0   = lpl_pkg::pow2n_tab({1'b0, w_pidx});
        w_pt1   = lpl_pkg::pow2n_tab({1'b0, w_pidx} + 6'd1);
        w_pprod = (w_pt0 - w_pt1) * w_prem;
        w_pg    = (w_pt0 - 17'(w_pprod >> 11)) >> r_l2g[17:16];
    end

    // output scaling and saturation
    logic [SW+16:0]       w_oprod;
    logic [SW:0]          w_omag;
    logic signed [SW-1:0] w_ores;
    always_comb begin
        w_oprod = r_dmag * r_g + (SW+17)'(32768);
        w_omag  = (SW+1)'(w_oprod >> 16);
        if (!r_dneg) begin
            w_ores = (w_omag > (SW+1)'({1'b0, {(SW-1){1'b1}}})) ?
                     {1'b0, {(SW-1){1'b1}}} : w_omag[SW-1:0];
        end else begin
            w_ores = (w_omag > (SW+1)'({1'b1, {(SW-1){1'b0}}})) ?
                     {1'b1, {(SW-1){1'b0}}} : (~w_omag[SW-1:0] + SW'(1));
        end
    end

    // sequencer, registers and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            o_valid   <= 1'b0;
            r_enable  <= 1'b1;
            r_ceiling <= '0;
            r_release <= 16'd65476;
            r_look    <= 9'd96;
            r_wp      <= '0;
            r_wrap    <= 1'b0;
            r_gain    <= '0;
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                unique case (lpl_pkg::t_reg_idx'(paddr[3:2]))
                    lpl_pkg::REG_ENABLE:  r_enable  <= pwdata[0];
                    lpl_pkg::REG_CEILING: r_ceiling <= pwdata[12:0];
                    lpl_pkg::REG_RELEASE: r_release <= pwdata[15:0];
                    lpl_pkg::REG_LOOKAHEAD: begin
                        r_look <= pwdata[8:0];
                        r_wp   <= '0;
                        r_wrap <= 1'b0;
                        r_gain <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_s <= i_sample_in;
                        if (r_enable) begin
                            r_rd_ok <= r_wrap || (w_nxt == '0);
                            r_wp    <= w_nxt;
                            if (w_nxt == '0) begin
                                r_wrap <= 1'b1;
                            end
                            r_state <= ST_MAG;
                        end else begin
                            r_res   <= i_sample_in;
                            r_red   <= '0;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_MAG: begin
                    r_mag   <= r_s[SW-1] ? (~r_s + SW'(1)) : r_s;
                    r_zero  <= (r_s == '0);
                    r_dneg  <= r_rd_ok && r_mem_q[SW-1];
                    r_dmag  <= !r_rd_ok ? '0 :
                               (r_mem_q[SW-1] ? (~r_mem_q + SW'(1)) : r_mem_q);
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    r_int   <= SW_M1 - w_e;
                    r_idx   <= w_n[30:26];
                    r_rem   <= w_n[25:16];
                    r_state <= ST_LOG;
                end
                ST_LOG: begin
                    r_l2    <= w_l2raw[21] ? '0 : w_l2raw[20:0];
                    r_state <= ST_ATTEN;
                end
                ST_ATTEN: begin
                    r_at    <= w_atprod[39:16];
                    r_state <= ST_REL;
                end
                ST_REL: begin
                    r_gain  <= w_rnew;
                    r_red   <= 12'((21'(w_rnew) + 21'd128) >> 8);
                    r_state <= ST_EXP;
                end
                ST_EXP: begin
                    r_l2g   <= w_l2gprod[33:16];
                    r_state <= ST_POW;
                end
                ST_POW: begin
                    r_g     <= w_pg;
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_res   <= w_ores;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        o_valid          <= 1'b1;
                        o_sample_out     <= r_res;
                        o_gain_reduction <= r_red;
                        r_state          <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (lpl_pkg::t_reg_idx'(paddr[3:2]))
            lpl_pkg::REG_ENABLE:    prdata = {31'd0, r_enable};
            lpl_pkg::REG_CEILING:   prdata = {19'd0, r_ceiling};
            lpl_pkg::REG_RELEASE:   prdata = {16'd0, r_release};
            lpl_pkg::REG_LOOKAHEAD: prdata = {23'd0, r_look};
            default:                prdata = '0;
        endcase
    end

    // held reduction never exceeds the lowest ceiling
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= {lpl_pkg::CEIL_MAX_ATTEN[11:0], 8'd0})
        else $error("held gain reduction out of range");

    // an accepted word blocks the input until its result is out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken while a word is in progress");

    // disabled words report no reduction
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !r_enable) |=> (r_state == ST_OUT && r_red == '0))
        else $error("bypass word did not go straight to output");

endmodule

### verif/tb_lookahead_peak_limiter.sv
// Self-checking testbench for the lookahead peak limiter: random and directed samples, APB setup.
module tb_lookahead_peak_limiter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 512;
    localparam int SW    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [SW-1:0] i_sample_in = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    logic [SW-1:0] o_sample_out;
    logic [11:0]   o_gain_reduction;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    lookahead_peak_limiter dut (.*);

    typedef struct packed {
        logic [SW-1:0] sample;
        logic [11:0]   gr;
    } t_word;

    // predictor state and registers
    logic signed [SW-1:0] pl_line [DEPTH];
    int unsigned pl_wptr;
    longint unsigned pl_red;
    logic        pl_en;
    logic [12:0] pl_ceil;
    logic [15:0] pl_rel;
    logic [8:0]  pl_look;

    logic [SW-1:0] send_q [$];
    t_word         limited_q [$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;

    initial forever #1 i_clk = ~i_clk;

    function automatic void clear_line();
        for (int i = 0; i < DEPTH; i++) pl_line[i] = '0;
        pl_wptr = 0;
        pl_red = 0;
    endfunction

    function automatic longint unsigned level_atten(longint unsigned mag);
        int e;
        longint unsigned nrm, frac, lf;
        int unsigned idx, rem;
        longint l2;
        e = 31;
        while (e > 0 && ((mag >> e) & 1) == 0) e--;
        nrm = (mag << (31 - e)) & 64'hFFFF_FFFF;
        frac = (nrm >> 16) & 16'h7FFF;
        idx = 32'(frac >> 10);
        rem = 32'(frac & 1023);
        lf = lpl_pkg::log2_tab(6'(idx)) + (((lpl_pkg::log2_tab(6'(idx + 1))
             - lpl_pkg::log2_tab(6'(idx))) * longint'(rem)) >> 10);
        l2 = longint'(SW - 1 - e) * 65536 - longint'(lf);
        if (l2 < 0) l2 = 0;
        return (longint'(l2) * 394566 + 32768) >> 16;
    endfunction

    function automatic longint unsigned lin_gain(longint unsigned r);
        longint unsigned l2, k, g;
        int unsigned f, idx, rem;
        l2 = (r * 10885 + 32768) >> 16;
        k = l2 >> 16;
        f = 32'(l2 & 16'hFFFF);
        idx = f >> 11;
        rem = f & 2047;
        g = lpl_pkg::pow2n_tab(6'(idx)) - (((lpl_pkg::pow2n_tab(6'(idx))
            - lpl_pkg::pow2n_tab(6'(idx + 1))) * longint'(rem)) >> 11);
        if (k > 31) return 0;
        return g >> k;
    endfunction

    // compute the limited word for one accepted sample
    function automatic t_word limit_sample(logic [SW-1:0] raw);
        t_word w;
        int unsigned len, ptr;
        longint s, dly, c, res;
        longint unsigned mag, want, cd, r, g, amag, prod, at;
        if (!pl_en) begin
            w.sample = raw;
            w.gr = '0;
            return w;
        end
        len = (pl_look < 1) ? 1 : 32'(pl_look);
        if (len > DEPTH - 1) len = DEPTH - 1;
        len++;
        ptr = pl_wptr;
        if (ptr >= len) ptr = 0;
        s = $signed(raw);
        pl_line[ptr] = raw;
        ptr++;
        if (ptr >= len) ptr = 0;
        dly = pl_line[ptr];
        pl_wptr = ptr;
        mag = (s < 0) ? -s : s;
        c = $signed(pl_ceil);
        if (c > 0) c = 0;
        if (c < -3072) c = -3072;
        cd = longint'(-c) << 8;
        want = 0;
        if (mag > 0) begin
            at = level_atten(mag);
            if (at < cd) want = cd - at;
        end
        r = pl_red;
        if (want > r) r = want;
        else r = want + ((longint'(pl_rel) * (r - want)) >> 16);
        pl_red = r;
        g = lin_gain(r);
        amag = (dly < 0) ? -dly : dly;
        prod = (amag * g + 32768) >> 16;
        res = (dly < 0) ? -longint'(prod) : longint'(prod);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        w.sample = res[SW-1:0];
        w.gr = 12'((r + 128) >> 8);
        return w;
    endfunction

    // sender: drive words from the pending queue, random idle bursts
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            limited_q.push_back(limit_sample(i_sample_in));
            if (!quiet && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 3);
                i_valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                i_sample_in <= send_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (gap > 0) gap = gap - 1;
            else if (send_q.size() > 0) begin
                i_sample_in <= send_q.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // receiver: random stall bursts plus one long counted hold-off on request
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: compare each output word with the oldest expectation
    always @(posedge i_clk) begin
        t_word w;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (limited_q.size() == 0) begin
                $display("%0t: unexpected word sample=%0d gr=%0d", $time,
                         $signed(o_sample_out), o_gain_reduction);
                errors++;
            end else begin
                w = limited_q.pop_front();
                if (w.sample !== o_sample_out) begin
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             $signed(w.sample), $signed(o_sample_out));
                    errors++;
                end
                if (w.gr !== o_gain_reduction) begin
                    $display("%0t: gain_reduction expected %0d actual %0d", $time,
                             w.gr, o_gain_reduction);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic apb_write(lpl_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            lpl_pkg::REG_ENABLE:  pl_en = val[0];
            lpl_pkg::REG_CEILING: pl_ceil = val[12:0];
            lpl_pkg::REG_RELEASE: pl_rel = val[15:0];
            default: begin
                pl_look = val[8:0];
                clear_line();
            end
        endcase
    endtask

    task automatic drain();
        wait (send_q.size() == 0 && !i_valid && limited_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    // mostly quiet material with loud peaks so that the limiter engages and releases
    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return SW'($urandom);
            1: return SW'($urandom_range(0, 255) - 128);
            2: return $urandom_range(0, 1) ? SW'(16'sd32767 - $urandom_range(0, 4000))
                                           : SW'(-16'sd32768 + $urandom_range(0, 4000));
            default: return SW'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    task automatic burst(int n);
        for (int i = 0; i < n; i++) send_q.push_back(rand_sample());
        drain();
    endtask

    initial begin
        pl_en = 1'b1; pl_ceil = '0; pl_rel = 16'd65476; pl_look = 9'd96;
        clear_line();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, zero, sign bits, with short lookahead and a ceiling just below 0 dB
        apb_write(lpl_pkg::REG_LOOKAHEAD, 32'd2);
        apb_write(lpl_pkg::REG_CEILING, 32'h1FF4);
        send_q = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000,
                   16'hC000, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'h0000};
        drain();
        // ceiling clamp both ways, zero lookahead, fast and slowest release
        apb_write(lpl_pkg::REG_CEILING, 32'h0100);
        apb_write(lpl_pkg::REG_LOOKAHEAD, 32'd0);
        apb_write(lpl_pkg::REG_RELEASE, 32'd0);
        send_q = '{16'h7FFF, 16'h8000, 16'h0010};
        drain();
        apb_write(lpl_pkg::REG_CEILING, 32'h1000);
        apb_write(lpl_pkg::REG_RELEASE, 32'hFFFF);
        send_q = '{16'h7FFF, 16'h0100, 16'h8000};
        drain();
        // disabled passthrough
        apb_write(lpl_pkg::REG_ENABLE, 32'd0);
        send_q = '{16'h8000, 16'h7FFF, 16'h1234};
        drain();
        apb_write(lpl_pkg::REG_ENABLE, 32'd1);
        // random phases across settings
        apb_write(lpl_pkg::REG_CEILING, 32'h1E00);
        apb_write(lpl_pkg::REG_RELEASE, 32'd60000);
        apb_write(lpl_pkg::REG_LOOKAHEAD, 32'd511);
        burst(300);
        apb_write(lpl_pkg::REG_LOOKAHEAD, 32'd7);
        apb_write(lpl_pkg::REG_CEILING, 32'h1F40);
        // long hold-off while the sender keeps offering
        for (int i = 0; i < 100; i++) send_q.push_back(rand_sample());
        hold_req = 1'b1;
        drain();
        hold_req = 1'b0;
        apb_write(lpl_pkg::REG_ENABLE, 32'd0);
        burst(100);
        apb_write(lpl_pkg::REG_ENABLE, 32'd1);
        apb_write(lpl_pkg::REG_RELEASE, 32'd1000);
        apb_write(lpl_pkg::REG_LOOKAHEAD, 32'd1);
        burst(300);
        apb_write(lpl_pkg::REG_CEILING, 32'd0);
        apb_write(lpl_pkg::REG_RELEASE, 32'd65476);
        apb_write(lpl_pkg::REG_LOOKAHEAD, 32'd96);
        burst(300);
        quiet = 1'b1;
        apb_write(lpl_pkg::REG_CEILING, 32'h1400);
        burst(200);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && limited_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
